/* rtl/cbdo_pkg.sv */
// ============================================================================
// cbdo_pkg - shared types and constants for the chamfered bar dim overlay
// Holds the configuration register map, the pixel and result structs and the
// dimming scale table.
// ============================================================================
package cbdo_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_BITS = 12;
    localparam int VIEW_BITS  = 13;
    localparam int CFG_BITS   = 12;
    localparam int PCT_BITS   = 7;
    localparam int CALC_W     = VIEW_BITS + 3;

    // Percentage scale: byte * pct / 100 == (byte * scale) >> SCALE_SHIFT
    localparam int PCT_FULL     = 100;
    localparam int SCALE_SHIFT  = 16;
    localparam int SCALE_BITS   = SCALE_SHIFT + 1;
    localparam int PCT_ENTRIES  = 1 << PCT_BITS;
    localparam int PROD_BITS    = 8 + SCALE_BITS;

    // Register indexes and reset values
    localparam int CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VIEW_WIDTH  = 3'd0,
        REG_BAR_LEFT    = 3'd1,
        REG_BAR_TOP_ROW = 3'd2,
        REG_BAR_HEIGHT  = 3'd3,
        REG_CORNER_SIZE = 3'd4,
        REG_DIM_PERCENT = 3'd5
    } t_reg_idx;

    localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RST  = VIEW_BITS'(640);
    localparam logic [CFG_BITS-1:0]  BAR_LEFT_RST    = CFG_BITS'(10);
    localparam logic [CFG_BITS-1:0]  BAR_TOP_ROW_RST = CFG_BITS'(0);
    localparam logic [CFG_BITS-1:0]  BAR_HEIGHT_RST  = CFG_BITS'(60);
    localparam logic [CFG_BITS-1:0]  CORNER_SIZE_RST = CFG_BITS'(5);
    localparam logic [PCT_BITS-1:0]  DIM_PERCENT_RST = PCT_BITS'(60);

    typedef logic [SCALE_BITS-1:0] t_scale;
    typedef t_scale t_scale_lut [PCT_ENTRIES];

    // Build the scale table: ceil(min(p,100) * 2^16 / 100). Rounding up keeps
    // the truncated product exact for every 8-bit byte.
    function automatic t_scale_lut build_scale_lut();
        t_scale_lut lut;
        int         p;
        for (int i = 0; i < PCT_ENTRIES; i++) begin
            p      = (i > PCT_FULL) ? PCT_FULL : i;
            lut[i] = SCALE_BITS'((p * (1 << SCALE_SHIFT) + PCT_FULL - 1) / PCT_FULL);
        end
        return lut;
    endfunction

    localparam t_scale_lut SCALE_LUT = build_scale_lut();

    // Live configuration
    typedef struct packed {
        logic [VIEW_BITS-1:0] view_width;
        logic [CFG_BITS-1:0]  bar_left;
        logic [CFG_BITS-1:0]  bar_top_row;
        logic [CFG_BITS-1:0]  bar_height;
        logic [CFG_BITS-1:0]  corner_size;
        t_scale               scale;
    } t_cfg;

    // One pixel with its position
    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [7:0]            byte0;
        logic [7:0]            byte1;
        logic [7:0]            byte2;
        logic [7:0]            byte3;
    } t_pix;

    // One result pixel
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       dimmed;
    } t_res;

endpackage

/* rtl/cbdo_core.sv */
// ============================================================================
// cbdo_core - band test and byte dimming for one pixel
// Decides whether the pixel falls in the chamfered bar and scales the three
// colour bytes by the configured percentage when it does.
// ============================================================================
module cbdo_core (
    input  cbdo_pkg::t_cfg i_cfg,
    input  cbdo_pkg::t_pix i_pix,
    output cbdo_pkg::t_res o_res
);
    import cbdo_pkg::*;

    logic signed [CALC_W-1:0] w_col;
    logic signed [CALC_W-1:0] w_row;
    logic signed [CALC_W-1:0] w_wid;
    logic signed [CALC_W-1:0] w_left;
    logic signed [CALC_W-1:0] w_top;
    logic signed [CALC_W-1:0] w_hgt;
    logic signed [CALC_W-1:0] w_cut;
    logic signed [CALC_W-1:0] w_h;
    logic signed [CALC_W-1:0] w_d;
    logic signed [CALC_W-1:0] w_e;
    logic signed [CALC_W-1:0] w_lo;
    logic signed [CALC_W-1:0] w_hi;
    logic signed [CALC_W-1:0] w_right;
    logic                     w_in_rows;
    logic                     w_in_cols;
    logic                     w_dim;
    logic [PROD_BITS-1:0]     w_prod0;
    logic [PROD_BITS-1:0]     w_prod1;
    logic [PROD_BITS-1:0]     w_prod2;

    // Widen everything to one signed width
    assign w_col  = signed'(CALC_W'(i_pix.column));
    assign w_row  = signed'(CALC_W'(i_pix.row));
    assign w_wid  = signed'(CALC_W'(i_cfg.view_width));
    assign w_left = signed'(CALC_W'(i_cfg.bar_left));
    assign w_top  = signed'(CALC_W'(i_cfg.bar_top_row));
    assign w_hgt  = signed'(CALC_W'(i_cfg.bar_height));
    assign w_cut  = signed'(CALC_W'(i_cfg.corner_size));

    // Row within the band and distance from its bottom edge
    assign w_h       = w_row - w_top;
    assign w_d       = w_hgt - w_h;
    assign w_in_rows = (w_h >= 0) && (w_h < w_hgt);

    // Pick how far the corner cut has receded: top corner, bottom corner, none
    always_comb begin
        if (w_h < w_cut) begin
            w_e = w_h;
        end else if (w_h > w_hgt - w_cut) begin
            w_e = w_d;
        end else begin
            w_e = w_cut;
        end
    end

    // Column limits of this row
    assign w_right   = w_wid - w_left;
    assign w_lo      = w_left + w_cut - w_e;
    assign w_hi      = w_right - w_cut + w_e;
    assign w_in_cols = (w_col < w_wid) && (w_col >= w_left) && (w_col <= w_right)
                    && (w_col >= w_lo) && (w_col <= w_hi);
    assign w_dim     = w_in_rows && w_in_cols;

    // Scale the colour bytes
    assign w_prod0 = PROD_BITS'(i_pix.byte0) * PROD_BITS'(i_cfg.scale);
    assign w_prod1 = PROD_BITS'(i_pix.byte1) * PROD_BITS'(i_cfg.scale);
    assign w_prod2 = PROD_BITS'(i_pix.byte2) * PROD_BITS'(i_cfg.scale);

    always_comb begin
        o_res.byte3  = i_pix.byte3;
        o_res.dimmed = w_dim;
        if (w_dim) begin
            o_res.byte0 = w_prod0[SCALE_SHIFT +: 8];
            o_res.byte1 = w_prod1[SCALE_SHIFT +: 8];
            o_res.byte2 = w_prod2[SCALE_SHIFT +: 8];
        end else begin
            o_res.byte0 = i_pix.byte0;
            o_res.byte1 = i_pix.byte1;
            o_res.byte2 = i_pix.byte2;
        end
    end

endmodule

/* rtl/chamfered_bar_dim_overlay.sv */
// ============================================================================
// chamfered_bar_dim_overlay - dim a horizontal bar with chamfered corners
// Top level: configuration registers, input register, result register.
// ============================================================================
// One pixel item can be accepted and one result item delivered in every
// clock while the output is not stalled. An item is taken into the input
// register when it is accepted and moves on into the result register, from
// which its result is taken (the band test and one 8x17 multiply per colour
// byte sit between the two registers). Back pressure on the output holds
// the result register; while a result waits, the input register still takes
// one item if it is empty, and otherwise advances only when the result
// register frees. Configuration writes are taken in any cycle and must only
// be issued while no item is in flight; the dim percentage is converted to a
// scale factor on write.
module chamfered_bar_dim_overlay (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cbdo_pkg::COORD_BITS-1:0]    i_column,
    input  logic [cbdo_pkg::COORD_BITS-1:0]    i_row,
    input  logic [7:0]                         i_byte0_in,
    input  logic [7:0]                         i_byte1_in,
    input  logic [7:0]                         i_byte2_in,
    input  logic [7:0]                         i_byte3_in,
    // Pixel output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_byte0_out,
    output logic [7:0]                         o_byte1_out,
    output logic [7:0]                         o_byte2_out,
    output logic [7:0]                         o_byte3_out,
    output logic                               o_dimmed,
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbdo_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [cbdo_pkg::VIEW_BITS-1:0]     i_cfg_data
);
    import cbdo_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic r_s1_valid;
    t_pix r_s1_pix;
    logic r_out_valid;
    t_res r_out;
    t_res w_res;
    logic w_out_free;
    logic w_in_take;

    // Configuration port never stalls
    assign o_cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_VIEW_WIDTH:  n_cfg.view_width  = i_cfg_data;
                REG_BAR_LEFT:    n_cfg.bar_left    = i_cfg_data[CFG_BITS-1:0];
                REG_BAR_TOP_ROW: n_cfg.bar_top_row = i_cfg_data[CFG_BITS-1:0];
                REG_BAR_HEIGHT:  n_cfg.bar_height  = i_cfg_data[CFG_BITS-1:0];
                REG_CORNER_SIZE: n_cfg.corner_size = i_cfg_data[CFG_BITS-1:0];
                REG_DIM_PERCENT: n_cfg.scale       = SCALE_LUT[i_cfg_data[PCT_BITS-1:0]];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_width  <= VIEW_WIDTH_RST;
            r_cfg.bar_left    <= BAR_LEFT_RST;
            r_cfg.bar_top_row <= BAR_TOP_ROW_RST;
            r_cfg.bar_height  <= BAR_HEIGHT_RST;
            r_cfg.corner_size <= CORNER_SIZE_RST;
            r_cfg.scale       <= SCALE_LUT[DIM_PERCENT_RST];
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Handshake: result register frees when empty or taken
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_pix.column <= i_column;
            r_s1_pix.row    <= i_row;
            r_s1_pix.byte0  <= i_byte0_in;
            r_s1_pix.byte1  <= i_byte1_in;
            r_s1_pix.byte2  <= i_byte2_in;
            r_s1_pix.byte3  <= i_byte3_in;
        end
    end

    // Band test and dimming
    cbdo_core u_core (
        .i_cfg (r_cfg),
        .i_pix (r_s1_pix),
        .o_res (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out <= w_res;
        end
    end

    // Drive outputs
    assign o_out_valid = r_out_valid;
    assign o_byte0_out = r_out.byte0;
    assign o_byte1_out = r_out.byte1;
    assign o_byte2_out = r_out.byte2;
    assign o_byte3_out = r_out.byte3;
    assign o_dimmed    = r_out.dimmed;

endmodule

/* rtl/cbdo_checker.sv */
// ============================================================================
// cbdo_checker - port-level checks for the chamfered bar dim overlay
// Watches the top level's ports and flags handshake and flow slips.
// ============================================================================
module cbdo_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [7:0]                         o_byte0_out,
    input  logic [7:0]                         o_byte1_out,
    input  logic [7:0]                         o_byte2_out,
    input  logic [7:0]                         o_byte3_out,
    input  logic                               o_dimmed,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_byte0_out) && $stable(o_byte1_out)
            && $stable(o_byte2_out) && $stable(o_byte3_out) && $stable(o_dimmed))
        else $error("stalled result changed");

    // An empty result register must never block the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Configuration port takes every write
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind chamfered_bar_dim_overlay cbdo_checker u_cbdo_checker (.*);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for the chamfered bar dim overlay
// Feeds pixel items with their column and row through the valid/ready input,
// predicts band test and percentage dimming of items with no typed expectation
// from a shadow copy of the bar registers and compares every result item field
// by field. A short table of directed items comes first, then fixed and random
// register settings, each with a stream of random pixels aimed at the band.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbdo_pkg::*;

    // Register indexes that map to no register
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int PCT_MAX     = 100;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 90;

    typedef enum logic {STEP_WRITE, STEP_PIXEL} t_step_kind;

    typedef struct {
        t_step_kind              kind;
        logic [CFG_IDX_BITS-1:0] index;
        logic [VIEW_BITS-1:0]    data;
        t_pix                    pix;
        bit                      typed;
        t_res                    want;
    } t_step;

    // Shadow copy of the bar registers
    typedef struct {
        logic [VIEW_BITS-1:0] width;
        logic [CFG_BITS-1:0]  left;
        logic [CFG_BITS-1:0]  top;
        logic [CFG_BITS-1:0]  height;
        logic [CFG_BITS-1:0]  corner;
        logic [PCT_BITS-1:0]  pct;
    } t_bar_cfg;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic [COORD_BITS-1:0]   i_column     = '0;
    logic [COORD_BITS-1:0]   i_row        = '0;
    logic [7:0]              i_byte0_in   = '0;
    logic [7:0]              i_byte1_in   = '0;
    logic [7:0]              i_byte2_in   = '0;
    logic [7:0]              i_byte3_in   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [7:0]              o_byte0_out;
    logic [7:0]              o_byte1_out;
    logic [7:0]              o_byte2_out;
    logic [7:0]              o_byte3_out;
    logic                    o_dimmed;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index  = '0;
    logic [VIEW_BITS-1:0]    i_cfg_data   = '0;

    // Typed expectation that travels with the item on the input
    bit       tag_typed = 1'b0;
    t_res     tag_want  = '0;

    t_bar_cfg bar;
    t_res     pending_pixels[$];
    int       mismatch_count = 0;
    int       result_count   = 0;

    chamfered_bar_dim_overlay i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_byte0_in  (i_byte0_in),
        .i_byte1_in  (i_byte1_in),
        .i_byte2_in  (i_byte2_in),
        .i_byte3_in  (i_byte3_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_byte0_out (o_byte0_out),
        .o_byte1_out (o_byte1_out),
        .o_byte2_out (o_byte2_out),
        .o_byte3_out (o_byte3_out),
        .o_dimmed    (o_dimmed),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes hang
    initial begin
        #2_000_000;
        $display("chamfered_bar_dim_overlay: mismatch");
        $finish;
    end

    // Apply a register write to the shadow copy; spare indexes are dropped
    function automatic void note_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                           logic [VIEW_BITS-1:0] data);
        case (idx)
            REG_VIEW_WIDTH:  bar.width  = data;
            REG_BAR_LEFT:    bar.left   = data[CFG_BITS-1:0];
            REG_BAR_TOP_ROW: bar.top    = data[CFG_BITS-1:0];
            REG_BAR_HEIGHT:  bar.height = data[CFG_BITS-1:0];
            REG_CORNER_SIZE: bar.corner = data[CFG_BITS-1:0];
            REG_DIM_PERCENT: bar.pct    = data[PCT_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Band test with the chamfered corners, then percentage dimming
    function automatic t_res predict_pixel(t_pix p);
        t_res   r;
        longint w, h, d, wd, lm, ht, cut;
        int     pct;
        bit     hit;
        wd  = bar.width;
        lm  = bar.left;
        ht  = bar.height;
        cut = bar.corner;
        w   = p.column;
        h   = longint'(p.row) - longint'(bar.top);
        hit = (h >= 0) && (h < ht) && (w < wd) && (w >= lm) && (w <= wd - lm);
        if (hit) begin
            if (h < cut) begin
                hit = !(w < lm + cut - h || w > wd - lm - cut + h);
            end else if (h > ht - cut) begin
                d   = ht - h;
                hit = !(w < lm + cut - d || w > wd - lm - cut + d);
            end
        end
        pct      = (int'(bar.pct) > PCT_MAX) ? PCT_MAX : int'(bar.pct);
        r.byte0  = hit ? 8'((int'(p.byte0) * pct) / PCT_MAX) : p.byte0;
        r.byte1  = hit ? 8'((int'(p.byte1) * pct) / PCT_MAX) : p.byte1;
        r.byte2  = hit ? 8'((int'(p.byte2) * pct) / PCT_MAX) : p.byte2;
        r.byte3  = p.byte3;
        r.dimmed = hit;
        return r;
    endfunction

    // Check results, track register writes, queue predictions for new items
    always @(posedge i_clk) begin : scoreboard
        t_res got;
        t_res want;
        t_pix seen;
        if (!i_rst_n) begin
            bar = '{width: 13'd640, left: 12'd10, top: 12'd0, height: 12'd60,
                    corner: 12'd5, pct: 7'd60};
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{byte0: o_byte0_out, byte1: o_byte1_out, byte2: o_byte2_out,
                        byte3: o_byte3_out, dimmed: o_dimmed};
                result_count++;
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: nothing pending, got %h %h %h %h dim %b",
                                 result_count, got.byte0, got.byte1, got.byte2,
                                 got.byte3, got.dimmed);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.byte0 !== want.byte0 || got.byte1 !== want.byte1 ||
                        got.byte2 !== want.byte2 || got.byte3 !== want.byte3 ||
                        got.dimmed !== want.dimmed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: want %h %h %h %h dim %b, got %h %h %h %h dim %b",
                                     result_count, want.byte0, want.byte1, want.byte2,
                                     want.byte3, want.dimmed, got.byte0, got.byte1,
                                     got.byte2, got.byte3, got.dimmed);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                note_reg_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                seen = '{column: i_column, row: i_row, byte0: i_byte0_in,
                         byte1: i_byte1_in, byte2: i_byte2_in, byte3: i_byte3_in};
                pending_pixels.push_back(tag_typed ? tag_want : predict_pixel(seen));
            end
        end
    end

    // Output back pressure: pick a new stall pattern whenever the current span runs out
    int unsigned stall_span = 0;
    int unsigned stall_mode = 0;
    logic [3:0]  stall_tick = '0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_tick <= stall_tick + 4'd1;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (stall_tick[1:0] == 2'd0);
            default: i_out_ready <= (stall_tick >= 4'd7);
        endcase
    end

    function automatic t_step reg_step(logic [CFG_IDX_BITS-1:0] idx,
                                       logic [VIEW_BITS-1:0] data);
        t_step s;
        s       = '{kind: STEP_WRITE, index: idx, data: data, pix: '0,
                    typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic t_step pix_step(int col, int row, logic [7:0] b0, logic [7:0] b1,
                                       logic [7:0] b2, logic [7:0] b3);
        t_step s;
        s       = '{kind: STEP_PIXEL, index: '0, data: '0, pix: '0, typed: 1'b0, want: '0};
        s.pix   = '{column: COORD_BITS'(col), row: COORD_BITS'(row),
                    byte0: b0, byte1: b1, byte2: b2, byte3: b3};
        return s;
    endfunction

    function automatic t_step known_step(int col, int row, logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3, logic [7:0] r0,
                                         logic [7:0] r1, logic [7:0] r2, logic dim);
        t_step s;
        s       = pix_step(col, row, b0, b1, b2, b3);
        s.typed = 1'b1;
        s.want  = '{byte0: r0, byte1: r1, byte2: r2, byte3: b3, dimmed: dim};
        return s;
    endfunction

    // Hold a register write until it is taken
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [VIEW_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Hold a pixel item until it is taken
    task automatic send_pixel(t_pix p, bit typed, t_res want);
        i_in_valid <= 1'b1;
        i_column   <= p.column;
        i_row      <= p.row;
        i_byte0_in <= p.byte0;
        i_byte1_in <= p.byte1;
        i_byte2_in <= p.byte2;
        i_byte3_in <= p.byte3;
        tag_typed  <= typed;
        tag_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Wait until every queued result has come back
    task automatic drain_results();
        do @(negedge i_clk); while (pending_pixels.size() != 0);
        @(posedge i_clk);
    endtask

    // Write all six registers with random unused upper data bits, sometimes also a spare index
    task automatic program_bar(int w, int l, int t, int h, int a, int p);
        write_reg(REG_VIEW_WIDTH, VIEW_BITS'(w));
        write_reg(REG_BAR_LEFT, {1'($urandom), CFG_BITS'(l)});
        write_reg(REG_BAR_TOP_ROW, {1'($urandom), CFG_BITS'(t)});
        write_reg(REG_BAR_HEIGHT, {1'($urandom), CFG_BITS'(h)});
        write_reg(REG_CORNER_SIZE, {1'($urandom), CFG_BITS'(a)});
        write_reg(REG_DIM_PERCENT, {6'($urandom), PCT_BITS'(p)});
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      VIEW_BITS'($urandom));
    endtask

    initial begin : stimulus
        t_step plan[$];
        t_pix  p;
        bit    streaming;
        bit    idling;
        int    burst;
        int    w, l, t, h, a, pct;
        int    col, row;

        streaming = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: reset settings first (margin 10, width 640, rows 0..59)
        plan.push_back(known_step(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
        plan.push_back(known_step(320, 30, 8'hFF, 8'hFF, 8'hFF, 8'hAA,
                                  8'h99, 8'h99, 8'h99, 1));
        plan.push_back(known_step(320, 0, 8'd100, 8'd200, 8'd50, 8'd7,
                                  8'd60, 8'd120, 8'd30, 1));
        // inside the top left corner cut
        plan.push_back(known_step(12, 0, 8'h11, 8'h22, 8'h33, 8'h44,
                                  8'h11, 8'h22, 8'h33, 0));
        plan.push_back(known_step(4095, 4095, 8'h01, 8'h02, 8'h03, 8'h04,
                                  8'h01, 8'h02, 8'h03, 0));
        plan.push_back(known_step(320, 60, 8'h55, 8'h66, 8'h77, 8'h88,
                                  8'h55, 8'h66, 8'h77, 0));
        plan.push_back(known_step(320, 59, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00, 1));
        // last column before the right margin
        plan.push_back(known_step(630, 30, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd1, 8'd1, 1));
        plan.push_back(known_step(631, 30, 8'h9A, 8'hBC, 8'hDE, 8'hF0,
                                  8'h9A, 8'hBC, 8'hDE, 0));
        // percentage above one hundred saturates, zero blacks out
        plan.push_back(reg_step(REG_DIM_PERCENT, 13'd127));
        plan.push_back(known_step(320, 30, 8'hFF, 8'h80, 8'h01, 8'h5A,
                                  8'hFF, 8'h80, 8'h01, 1));
        plan.push_back(reg_step(REG_DIM_PERCENT, 13'd0));
        plan.push_back(known_step(320, 30, 8'hFF, 8'h80, 8'h01, 8'h5A,
                                  8'h00, 8'h00, 8'h00, 1));
        // empty band
        plan.push_back(reg_step(REG_BAR_HEIGHT, 13'd0));
        plan.push_back(known_step(320, 0, 8'h12, 8'h34, 8'h56, 8'h78,
                                  8'h12, 8'h34, 8'h56, 0));
        // band on the last row and column of the coordinate range
        plan.push_back(reg_step(REG_DIM_PERCENT, 13'd100));
        plan.push_back(reg_step(REG_VIEW_WIDTH, 13'h1000));
        plan.push_back(reg_step(REG_BAR_LEFT, 13'd0));
        plan.push_back(reg_step(REG_BAR_TOP_ROW, 13'd4095));
        plan.push_back(reg_step(REG_BAR_HEIGHT, 13'd4095));
        plan.push_back(reg_step(REG_CORNER_SIZE, 13'd0));
        plan.push_back(known_step(4095, 4095, 8'hAB, 8'hCD, 8'hEF, 8'h12,
                                  8'hAB, 8'hCD, 8'hEF, 1));
        plan.push_back(known_step(0, 4094, 8'hAB, 8'hCD, 8'hEF, 8'h12,
                                  8'hAB, 8'hCD, 8'hEF, 0));
        // zero width frame
        plan.push_back(reg_step(REG_VIEW_WIDTH, 13'd0));
        plan.push_back(known_step(0, 4095, 8'h13, 8'h57, 8'h9B, 8'hDF,
                                  8'h13, 8'h57, 8'h9B, 0));
        // margins that cross
        plan.push_back(reg_step(REG_VIEW_WIDTH, 13'd100));
        plan.push_back(reg_step(REG_BAR_LEFT, 13'd60));
        plan.push_back(reg_step(REG_BAR_TOP_ROW, 13'd0));
        plan.push_back(reg_step(REG_BAR_HEIGHT, 13'd10));
        plan.push_back(known_step(50, 5, 8'hFE, 8'hDC, 8'hBA, 8'h98,
                                  8'hFE, 8'hDC, 8'hBA, 0));
        // corner edges, masked upper data bit, then writes to spare indexes
        plan.push_back(reg_step(REG_VIEW_WIDTH, 13'd200));
        plan.push_back(reg_step(REG_BAR_LEFT, 13'h1000));
        plan.push_back(reg_step(REG_BAR_TOP_ROW, 13'd100));
        plan.push_back(reg_step(REG_BAR_HEIGHT, 13'd20));
        plan.push_back(reg_step(REG_CORNER_SIZE, 13'd8));
        plan.push_back(reg_step(REG_DIM_PERCENT, 13'h1F32));
        plan.push_back(reg_step(REG_SPARE_LO, 13'd0));
        plan.push_back(reg_step(REG_SPARE_HI, 13'h1FFF));
        plan.push_back(pix_step(7, 100, 8'hC8, 8'h64, 8'h33, 8'h01));
        plan.push_back(pix_step(8, 100, 8'hC8, 8'h64, 8'h33, 8'h02));
        plan.push_back(pix_step(192, 100, 8'hC9, 8'h65, 8'h35, 8'h03));
        plan.push_back(pix_step(193, 100, 8'hC9, 8'h65, 8'h35, 8'h04));
        plan.push_back(pix_step(100, 119, 8'h7F, 8'h80, 8'h81, 8'h05));
        plan.push_back(pix_step(6, 119, 8'h7F, 8'h80, 8'h81, 8'h06));
        plan.push_back(pix_step(7, 119, 8'h7F, 8'h80, 8'h81, 8'h07));
        plan.push_back(pix_step(100, 99, 8'hFF, 8'hFF, 8'hFF, 8'h08));

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) begin
                if (streaming) begin
                    i_in_valid <= 1'b0;
                    drain_results();
                    streaming = 1'b0;
                end
                write_reg(plan[i].index, plan[i].data);
            end else begin
                if (!streaming) begin
                    i_cfg_valid <= 1'b0;
                    streaming = 1'b1;
                end
                send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
            end
        end

        // Fixed, then random settings, each followed by a stream of pixels aimed at the band
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            drain_results();
            case (ph)
                0: begin w = 1;    l = 0;    t = 0;    h = 1;    a = 0;    pct = 0;   end
                1: begin w = 8191; l = 4095; t = 4095; h = 4095; a = 4095; pct = 127; end
                2: begin w = 4096; l = 0;    t = 0;    h = 4095; a = 0;    pct = 100; end
                default: begin
                    w   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(16, 1024);
                    l   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, w / 3);
                    t   = $urandom_range(0, 4095);
                    h   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(0, 64);
                    a   = $urandom_range(0, h / 2 + 3);
                    pct = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                               : $urandom_range(0, 100);
                end
            endcase
            program_bar(w, l, t, h, a, pct);
            i_cfg_valid <= 1'b0;
            idling = (ph % 3 != 2);
            burst  = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // let the pipe run dry once in a while
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) begin
                    i_in_valid <= 1'b0;
                    drain_results();
                end
                case ($urandom_range(0, 3))
                    0: begin
                        col = $urandom_range(0, 4095);
                        row = $urandom_range(0, 4095);
                    end
                    1: begin
                        row = t + $urandom_range(0, h + 3) - 2;
                        col = $urandom_range(0, w + 2);
                    end
                    2: begin
                        row = t + $urandom_range(0, a + 1) - 1;
                        col = l + $urandom_range(0, 2 * a + 4) - 2;
                    end
                    default: begin
                        row = t + h - $urandom_range(0, a + 1);
                        col = w - l - $urandom_range(0, 2 * a + 4) + 2;
                    end
                endcase
                p = '{column: COORD_BITS'(col), row: COORD_BITS'(row),
                      byte0: 8'($urandom), byte1: 8'($urandom),
                      byte2: 8'($urandom), byte3: 8'($urandom)};
                send_pixel(p, 1'b0, '0);
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 40);
                    if (idling) begin
                        i_in_valid <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(posedge i_clk);
                    end
                end
            end
        end

        // Let everything come back, then wait on for stray results
        i_in_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("chamfered_bar_dim_overlay: match");
        end else begin
            $display("chamfered_bar_dim_overlay: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/cbdo_pkg.sv
rtl/cbdo_core.sv
rtl/chamfered_bar_dim_overlay.sv
rtl/cbdo_checker.sv
sim/tb_top.sv
